// File: hdl/kstf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kstf_pkg
// Types, register indexes and helpers shared by the tilt filter modules.
// ----------------------------------------------------------------------------
package kstf_pkg;

    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] CFG_GYRO_OFFSET  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_ACCEL_OFFSET = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_PERIOD       = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_PROC_NOISE   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_MEAS_NOISE   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_ANGLE_BIAS   = 3'd5;

    localparam logic [23:0] PERIOD_RST     = 24'd83886;
    localparam logic [31:0] PROC_NOISE_RST = 32'd655360;
    localparam logic [31:0] MEAS_NOISE_RST = 32'd131072000;
    localparam logic [31:0] ANGLE_BIAS_RST = 32'hFFF4_8000;

    localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
    localparam logic [31:0] Q31_ONE = 32'h8000_0000;

    typedef enum logic [17:0] {
        ST_IDLE  = 18'b000000000000000001,
        ST_MRATE = 18'b000000000000000010,
        ST_PRIOR = 18'b000000000000000100,
        ST_MQ    = 18'b000000000000001000,
        ST_SUM1  = 18'b000000000000010000,
        ST_SQ1   = 18'b000000000000100000,
        ST_MPP   = 18'b000000000001000000,
        ST_MR    = 18'b000000000010000000,
        ST_DEN   = 18'b000000000100000000,
        ST_DIV   = 18'b000000001000000000,
        ST_SQ2   = 18'b000000010000000000,
        ST_MCL   = 18'b000000100000000000,
        ST_MCH   = 18'b000001000000000000,
        ST_EST   = 18'b000010000000000000,
        ST_SQ4   = 18'b000100000000000000,
        ST_MCOV  = 18'b001000000000000000,
        ST_COV   = 18'b010000000000000000,
        ST_OUT   = 18'b100000000000000000
    } kstf_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -36'sh0_8000_0000)
            r = -32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/kstf_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kstf_isqrt
// Floored integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module kstf_isqrt
    import kstf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] operand,
    output logic             done,
    output logic [31:0]      root
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= operand;
            res_reg <= '0;
            bit_reg <= Q62_ONE;
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_reg   <= x_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule
`default_nettype wire

// File: hdl/scalar_kalman_tilt_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scalar_kalman_tilt_filter
// Fixed-point scalar Kalman filter fusing gyro rate and accelerometer angle.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid/in_stall) carries one gyro and one accel sample
//   per transaction; output channel (out_valid/out_stall) returns the fused
//   angle (Q16.16, saturated, plus angle_bias) and the corrected gyro rate.
//   registers are written through cfg_write/cfg_index/cfg_data while idle.
// Timing:
//   one transaction is worked at a time by a sequencer around one shared
//   32x32 multiplier, a bit-serial square root (used up to three times)
//   and a restoring divider. the covariance root is skipped when the prior
//   covariance saturates, the division with full gain, and both the
//   division and the gain root with zero gain.
//   in_stall stays high from acceptance until the result is loaded into the
//   output register; the next transaction can then be taken while the
//   result waits. a stalled output holds; the block waits for it to drain
//   before loading the next result.
// Reset: clears angle estimate and covariance to zero and loads register
//   defaults (period about 1/200 s, Q = 10.0, R = 2000.0, bias = -11.5).
// ----------------------------------------------------------------------------
module scalar_kalman_tilt_filter
    import kstf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] gyro_sample,
    input  wire logic signed [15:0] accel_sample,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      filtered_angle,
    output logic signed [16:0]      angle_rate,
    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    kstf_state_t state_reg, state_next;

    logic signed [15:0] gyro_off_reg;
    logic signed [15:0] accel_off_reg;
    logic [23:0]        period_reg;
    logic [31:0]        qn_reg;
    logic [31:0]        rn_reg;
    logic signed [31:0] bias_reg;

    logic signed [31:0] est_reg;
    logic [31:0]        cov_reg;

    logic signed [16:0] rate_reg;
    logic signed [16:0] acc_reg;
    logic signed [31:0] prior_reg;
    logic [31:0]        pp_reg;
    logic [31:0]        k_reg;
    logic [31:0]        s_reg;
    logic [63:0]        sum_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        rem_reg;
    logic [63:0]        den_reg;
    logic [62:0]        q_reg;
    logic [5:0]         cnt_reg;

    logic               out_valid_reg;
    logic signed [31:0] angle_out_reg;
    logic signed [16:0] rate_out_reg;

    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [16:0]        rate_mag;
    logic [40:0]        rnd_sum;
    logic signed [35:0] rnd_term;
    logic [64:0]        sum65;
    logic [63:0]        num_sel;
    logic [63:0]        den_sel;
    logic signed [33:0] diff;
    logic [33:0]        mag;
    logic [65:0]        corr_sum;
    logic [34:0]        corr;
    logic signed [35:0] est_wide;
    logic [64:0]        rem2;
    logic               div_take;
    logic [62:0]        q_next;
    logic               sqrt_start;
    logic [63:0]        sqrt_arg;
    logic               sqrt_done;
    logic [31:0]        sqrt_root;
    logic               accept;
    logic               out_load;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    // datapath helpers
    assign rate_mag = rate_reg[16] ? 17'(-rate_reg) : 17'(rate_reg);
    assign rnd_sum  = prod_reg[40:0] + 41'd128;
    assign rnd_term = rate_reg[16] ? -$signed({3'b000, rnd_sum[40:8]})
                                   : $signed({3'b000, rnd_sum[40:8]});
    assign sum65    = {1'b0, sum_reg} + {1'b0, prod_reg};
    assign num_sel  = sum65[64] ? (sum_reg >> 1) : sum_reg;
    assign den_sel  = sum65[64] ? sum65[64:1] : sum65[63:0];
    assign diff     = {acc_reg[16], acc_reg, 16'h0000} - 34'(prior_reg);
    assign mag      = diff[33] ? 34'(-diff) : 34'(diff);
    assign corr_sum = {2'b00, sum_reg} + {prod_reg[33:0], 32'h0} + 66'h4000_0000;
    assign corr     = corr_sum[65:31];
    assign est_wide = diff[33] ? (36'(prior_reg) - $signed({1'b0, corr}))
                               : (36'(prior_reg) + $signed({1'b0, corr}));
    assign rem2     = {rem_reg, 1'b0};
    assign div_take = (rem2 >= {1'b0, den_reg});
    assign q_next   = {q_reg[61:0], div_take};

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MRATE:
            begin
                mul_a = 32'(rate_mag);
                mul_b = 32'(period_reg);
            end
            ST_PRIOR:
            begin
                mul_a = cov_reg;
                mul_b = cov_reg;
            end
            ST_MQ:
            begin
                mul_a = qn_reg;
                mul_b = qn_reg;
            end
            ST_MPP:
            begin
                mul_a = pp_reg;
                mul_b = pp_reg;
            end
            ST_MR:
            begin
                mul_a = rn_reg;
                mul_b = rn_reg;
            end
            ST_MCL:
            begin
                mul_a = mag[31:0];
                mul_b = k_reg;
            end
            ST_MCH:
            begin
                mul_a = {30'h0, mag[33:32]};
                mul_b = k_reg;
            end
            ST_MCOV:
            begin
                mul_a = pp_reg;
                mul_b = s_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        sqrt_start = 1'b0;
        sqrt_arg   = '0;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_MRATE;
            ST_MRATE: state_next = ST_PRIOR;
            ST_PRIOR: state_next = ST_MQ;
            ST_MQ:    state_next = ST_SUM1;
            ST_SUM1:
            begin
                if (sum65[64])
                    state_next = ST_MPP;
                else
                begin
                    sqrt_start = 1'b1;
                    sqrt_arg   = sum65[63:0];
                    state_next = ST_SQ1;
                end
            end
            ST_SQ1:   if (sqrt_done) state_next = ST_MPP;
            ST_MPP:   state_next = ST_MR;
            ST_MR:    state_next = ST_DEN;
            ST_DEN:
            begin
                if (den_sel == 64'h0)
                    state_next = ST_MCL;
                else if (num_sel >= den_sel)
                begin
                    sqrt_start = 1'b1;
                    sqrt_arg   = Q62_ONE;
                    state_next = ST_SQ2;
                end
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == 6'd61)
                begin
                    sqrt_start = 1'b1;
                    sqrt_arg   = {1'b0, q_next};
                    state_next = ST_SQ2;
                end
            end
            ST_SQ2:   if (sqrt_done) state_next = ST_MCL;
            ST_MCL:   state_next = ST_MCH;
            ST_MCH:   state_next = ST_EST;
            ST_EST:
            begin
                sqrt_start = 1'b1;
                sqrt_arg   = {1'b0, (Q31_ONE - k_reg), 31'h0};
                state_next = ST_SQ4;
            end
            ST_SQ4:   if (sqrt_done) state_next = ST_MCOV;
            ST_MCOV:  state_next = ST_COV;
            ST_COV:   state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state, configuration and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            gyro_off_reg  <= '0;
            accel_off_reg <= '0;
            period_reg    <= PERIOD_RST;
            qn_reg        <= PROC_NOISE_RST;
            rn_reg        <= MEAS_NOISE_RST;
            bias_reg      <= ANGLE_BIAS_RST;
            est_reg       <= '0;
            cov_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_GYRO_OFFSET:  gyro_off_reg  <= cfg_data[15:0];
                    CFG_ACCEL_OFFSET: accel_off_reg <= cfg_data[15:0];
                    CFG_PERIOD:       period_reg    <= cfg_data[23:0];
                    CFG_PROC_NOISE:   qn_reg        <= cfg_data;
                    CFG_MEAS_NOISE:   rn_reg        <= cfg_data;
                    CFG_ANGLE_BIAS:   bias_reg      <= cfg_data;
                    default:          ;
                endcase
            end
            if (state_reg == ST_EST)
                est_reg <= sat32(est_wide);
            if (state_reg == ST_COV)
                cov_reg <= prod_reg[62:31];
            if (state_reg == ST_DIV)
                cnt_reg <= cnt_reg + 6'd1;
            else
                cnt_reg <= '0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (accept)
        begin
            rate_reg <= 17'(gyro_sample) - 17'(gyro_off_reg);
            acc_reg  <= 17'(accel_sample) - 17'(accel_off_reg);
        end
        case (state_reg)
            ST_PRIOR: prior_reg <= sat32(36'(est_reg) + rnd_term);
            ST_MQ:    sum_reg   <= prod_reg;
            ST_SUM1:  if (sum65[64]) pp_reg <= 32'hFFFF_FFFF;
            ST_SQ1:   if (sqrt_done) pp_reg <= sqrt_root;
            ST_MR:    sum_reg   <= prod_reg;
            ST_DEN:
            begin
                rem_reg <= num_sel;
                den_reg <= den_sel;
                q_reg   <= '0;
                if (den_sel == 64'h0)
                    k_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= div_take ? 64'(rem2 - {1'b0, den_reg}) : rem2[63:0];
                q_reg   <= q_next;
            end
            ST_SQ2:   if (sqrt_done) k_reg <= sqrt_root;
            ST_MCH:   sum_reg   <= prod_reg;
            ST_SQ4:   if (sqrt_done) s_reg <= sqrt_root;
            default:  ;
        endcase
        if (out_load)
        begin
            angle_out_reg <= sat32(36'(est_reg) + 36'(bias_reg));
            rate_out_reg  <= rate_reg;
        end
    end

    kstf_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (sqrt_arg),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    assign out_valid      = out_valid_reg;
    assign filtered_angle = angle_out_reg;
    assign angle_rate     = rate_out_reg;

endmodule
`default_nettype wire
